// ===== design/lrst_pkg.sv =====
// Shared operation codes and field widths for the lazy range sum tree.
`default_nettype none
package lrst_pkg;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 10;
    localparam int OPD_W  = 32;
    localparam int SUM_W  = 64;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [SUM_W-1:0]  sum_t;

    localparam func_t FUNC_POINT_SET    = 3'd0;
    localparam func_t FUNC_POINT_ADD    = 3'd1;
    localparam func_t FUNC_RANGE_ASSIGN = 3'd2;
    localparam func_t FUNC_RANGE_ADD    = 3'd3;
    localparam func_t FUNC_RANGE_QUERY  = 3'd4;
endpackage
`default_nettype wire

// ===== design/lazy_range_sum_tree_top.sv =====
// Range assign / range add / range sum engine over a signed value array.
//
// Input channel (s_*): one request per operation: point set, point add,
// range assign, range add or range sum query, with positions and operand.
// Result channel (m_*): one result per range sum query only; range_sum is
// the wrapped 64-bit sum, bad_range flags an empty or out-of-bounds range.
// Updates with a bad range or position, and unused codes, are dropped.
//
// The array lives in one RAM (one entry per position, registered read).
// An operation sweeps one position per cycle, a read-modify-write for an update.
// An accepted update sweeps in ST_RUN and returns to idle; an accepted
// query sweeps in ST_RUN and then passes ST_OUT, where its result is
// registered. A dropped update leaves the engine idle; a flagged query
// goes straight to ST_OUT. One request is in work at a time; s_ready is
// high only while the engine is idle.
// A query result is held in an output register until taken; while the
// receiver stalls with a result pending, a finished query waits for it.
// After reset a clearing pass writes zero to every one of the
// min(LEAVES, 1024) entries, one per cycle; no request is accepted until it ends.
`default_nettype none
module lazy_range_sum_tree_top import lrst_pkg::*; #(
    parameter int LEAVES = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [FUNC_W-1:0] s_func,
    input  wire logic [POS_W-1:0]  s_left_pos,
    input  wire logic [POS_W-1:0]  s_right_pos,
    input  wire logic signed [OPD_W-1:0] s_operand,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [SUM_W-1:0] m_range_sum,
    output logic                   m_bad_range
);
    // Positions are 10 bits wide, so at most 1024 entries are reachable.
    localparam int DEPTH = (LEAVES < (1 << POS_W)) ? LEAVES : (1 << POS_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [POS_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] hi_reg, hi_next;
    logic             issue_reg, issue_next;
    logic             pv_reg, pv_next;
    logic [AW-1:0]    pa_reg, pa_next;
    func_t            op_reg, op_next;
    sum_t             val_reg, val_next;
    sum_t             acc_reg, acc_next;
    logic             bad_reg, bad_next;
    logic             m_valid_reg, m_valid_next;
    sum_t             m_sum_reg, m_sum_next;
    logic             m_bad_reg, m_bad_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    sum_t          ram_wdata, ram_rdata;

    logic fire, l_ok, r_ok, range_ok, is_point;

    lrst_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign fire        = s_valid && s_ready;
    assign l_ok        = {7'd0, s_left_pos} < 17'(DEPTH);
    assign r_ok        = {7'd0, s_right_pos} < 17'(DEPTH);
    assign range_ok    = l_ok && r_ok && (s_left_pos <= s_right_pos);
    assign is_point    = (s_func == FUNC_POINT_SET) || (s_func == FUNC_POINT_ADD);
    assign ram_raddr   = cnt_reg[AW-1:0];

    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_sum_reg;
    assign m_bad_range = m_bad_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        hi_next      = hi_reg;
        issue_next   = issue_reg;
        pv_next      = 1'b0;
        pa_next      = pa_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_sum_next   = m_sum_reg;
        m_bad_next   = m_bad_reg;
        ram_we       = 1'b0;
        ram_waddr    = pa_reg;
        ram_wdata    = '0;

        unique case (state_reg)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[AW-1:0] == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (fire) begin
                    op_next  = s_func;
                    val_next = SUM_W'(s_operand);
                    cnt_next = s_left_pos;
                    hi_next  = is_point ? s_left_pos : s_right_pos;
                    acc_next = '0;
                    bad_next = 1'b0;
                    if (s_func == FUNC_RANGE_QUERY) begin
                        if (range_ok) begin
                            issue_next = 1'b1;
                            state_next = ST_RUN;
                        end else begin
                            bad_next   = 1'b1;
                            state_next = ST_OUT;
                        end
                    end else if ((is_point && l_ok) ||
                                 (s_func == FUNC_RANGE_ASSIGN && range_ok) ||
                                 (s_func == FUNC_RANGE_ADD && range_ok)) begin
                        issue_next = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (issue_reg) begin
                    pv_next  = 1'b1;
                    pa_next  = cnt_reg[AW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == hi_reg) begin
                        issue_next = 1'b0;
                    end
                end
                if (pv_reg) begin
                    if (op_reg == FUNC_RANGE_QUERY) begin
                        acc_next = acc_reg + ram_rdata;
                    end else begin
                        ram_we = 1'b1;
                        if (op_reg == FUNC_POINT_SET || op_reg == FUNC_RANGE_ASSIGN) begin
                            ram_wdata = val_reg;
                        end else begin
                            ram_wdata = ram_rdata + val_reg;
                        end
                    end
                end
                if (!issue_reg && !pv_reg) begin
                    state_next = (op_reg == FUNC_RANGE_QUERY) ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = acc_reg;
                    m_bad_next   = bad_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            issue_reg   <= 1'b0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            issue_reg   <= issue_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg    <= hi_next;
        pa_reg    <= pa_next;
        op_reg    <= op_next;
        val_reg   <= val_next;
        acc_reg   <= acc_next;
        bad_reg   <= bad_next;
        m_sum_reg <= m_sum_next;
        m_bad_reg <= m_bad_next;
    end
endmodule
`default_nettype wire

// ===== design/lrst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lrst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/lrst_checker.sv =====
// Port-level checks for the lazy range sum tree, bound to its top level.
`default_nettype none
module lrst_checker import lrst_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic [FUNC_W-1:0] s_func,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [SUM_W-1:0]  m_range_sum,
    input wire logic              m_bad_range
);
    // A flagged query always reports a zero sum.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_range |-> m_range_sum == '0)
        else $error("bad range result with nonzero sum");

    // No result may show right after reset.
    a_rst_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An accepted query keeps the engine busy for at least the next cycle.
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_RANGE_QUERY |=> !s_ready)
        else $error("request accepted while busy");

    // Non-query requests never produce a result in the following cycle.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func != FUNC_RANGE_QUERY && !m_valid |=> !m_valid)
        else $error("result from a non-query request");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_sum) && $stable(m_bad_range))
        else $error("stalled result changed");
endmodule

bind lazy_range_sum_tree_top lrst_checker u_lrst_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_func      (s_func),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_range_sum (m_range_sum),
    .m_bad_range (m_bad_range)
);
`default_nettype wire

// ===== dv/lazy_range_sum_tree_top_tb.sv =====
// Self-checking testbench for the lazy range sum tree engine.
`default_nettype none
module lazy_range_sum_tree_top_tb;
    import lrst_pkg::*;

    localparam int NPOS      = 1024;
    localparam int N_RANDOM  = 1430;
    localparam int CALM_TAIL = 150;        // no idling on either side for the last requests
    localparam int LIMIT     = 4000000;
    localparam int STALL_AT  = 300;        // request count that triggers the long receiver hold
    localparam int STALL_LEN = 3000;

    typedef struct {
        func_t                   func;
        logic [POS_W-1:0]        lpos;
        logic [POS_W-1:0]        rpos;
        logic signed [OPD_W-1:0] opd;
        bit                      drain;    // hold this request until every result is back
    } tree_req_t;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic                    bad;
    } sum_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [FUNC_W-1:0] s_func = '0;
    logic [POS_W-1:0]  s_left_pos = '0;
    logic [POS_W-1:0]  s_right_pos = '0;
    logic signed [OPD_W-1:0] s_operand = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SUM_W-1:0] m_range_sum;
    logic m_bad_range;

    lazy_range_sum_tree_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .s_left_pos(s_left_pos), .s_right_pos(s_right_pos),
        .s_operand(s_operand),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_range_sum(m_range_sum), .m_bad_range(m_bad_range)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Shadow array: the engine itself keeps one flat array of values,
    // so a flat array with wrapping adds predicts every sum exactly.
    logic signed [SUM_W-1:0] shadow [NPOS];
    tree_req_t pending_reqs[$];
    sum_res_t  expected_sums[$];
    int  accepted = 0;
    int  mismatches = 0;
    bit  stim_done = 1'b0;

    task automatic queue_req(input tree_req_t rq);
        pending_reqs = {pending_reqs, rq};
    endtask

    task automatic apply_request(input tree_req_t rq, output bit has_res, output sum_res_t res);
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] acc;
        bit range_ok;
        v = SUM_W'(rq.opd);                // sign-extend
        range_ok = (rq.lpos < NPOS) && (rq.rpos < NPOS) && (rq.lpos <= rq.rpos);
        has_res = 1'b0;
        res.sum = '0;
        res.bad = 1'b0;
        case (rq.func)
            FUNC_POINT_SET: begin
                if (rq.lpos < NPOS) shadow[rq.lpos] = v;
            end
            FUNC_POINT_ADD: begin
                if (rq.lpos < NPOS) shadow[rq.lpos] += v;
            end
            FUNC_RANGE_ASSIGN: begin
                if (range_ok) for (int i = rq.lpos; i <= rq.rpos; i++) shadow[i] = v;
            end
            FUNC_RANGE_ADD: begin
                if (range_ok) for (int i = rq.lpos; i <= rq.rpos; i++) shadow[i] += v;
            end
            FUNC_RANGE_QUERY: begin
                has_res = 1'b1;
                if (range_ok) begin
                    acc = '0;
                    for (int i = rq.lpos; i <= rq.rpos; i++) acc += shadow[i];
                    res.sum = acc;
                end else begin
                    res.bad = 1'b1;
                end
            end
            default: ;                     // unused codes are dropped by the engine
        endcase
    endtask

    function automatic tree_req_t mk_req(func_t f, int l, int r, logic signed [OPD_W-1:0] o);
        tree_req_t rq;
        rq.func = f;
        rq.lpos = POS_W'(l);
        rq.rpos = POS_W'(r);
        rq.opd = o;
        rq.drain = 1'b0;
        return rq;
    endfunction

    function automatic logic signed [OPD_W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -32'sd1;
            3: return OPD_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Mostly short spans keep the sweep time low; a few span up to the whole array.
    function automatic tree_req_t rand_request();
        tree_req_t rq;
        int l, len, pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = $urandom_range(1, 16);
        else if (pick < 94) len = $urandom_range(1, 128);
        else                len = $urandom_range(1, NPOS);
        l = $urandom_range(0, NPOS - len);
        pick = $urandom_range(0, 99);
        if (pick < 12)      rq = mk_req(FUNC_POINT_SET, l, $urandom_range(0, NPOS - 1), 0);
        else if (pick < 24) rq = mk_req(FUNC_POINT_ADD, l, $urandom_range(0, NPOS - 1), 0);
        else if (pick < 40) rq = mk_req(FUNC_RANGE_ASSIGN, l, l + len - 1, 0);
        else if (pick < 56) rq = mk_req(FUNC_RANGE_ADD, l, l + len - 1, 0);
        else if (pick < 92) rq = mk_req(FUNC_RANGE_QUERY, l, l + len - 1, 0);
        else if (pick < 95) rq = mk_req(func_t'($urandom_range(5, 7)), $urandom_range(0, NPOS - 1),
                                        $urandom_range(0, NPOS - 1), 0);
        else begin
            // reversed range: the query flags it, updates drop it
            l = $urandom_range(1, NPOS - 1);
            rq = mk_req(func_t'($urandom_range(2, 4)), l, $urandom_range(0, l - 1), 0);
        end
        rq.opd = rand_operand();
        return rq;
    endfunction

    initial begin
        // Directed part: field extremes, every operation, the rejected cases.
        queue_req(mk_req(FUNC_RANGE_QUERY, 0, NPOS - 1, 0));
        queue_req(mk_req(FUNC_POINT_SET, 0, 1023, 32'sh7fffffff));
        queue_req(mk_req(FUNC_POINT_SET, NPOS - 1, 0, 32'sh80000000));
        queue_req(mk_req(FUNC_POINT_ADD, 0, 5, -32'sd1));
        queue_req(mk_req(FUNC_RANGE_QUERY, 0, 0, 0));
        queue_req(mk_req(FUNC_RANGE_QUERY, NPOS - 1, NPOS - 1, 0));
        queue_req(mk_req(FUNC_RANGE_ASSIGN, 0, NPOS - 1, 32'sh7fffffff));
        queue_req(mk_req(FUNC_RANGE_ADD, 0, NPOS - 1, 32'sh7fffffff));
        queue_req(mk_req(FUNC_RANGE_QUERY, 0, NPOS - 1, 32'sh12345678));
        queue_req(mk_req(FUNC_RANGE_ADD, 100, 611, 32'sh80000000));
        queue_req(mk_req(FUNC_RANGE_ASSIGN, 300, 400, -32'sd7));
        queue_req(mk_req(FUNC_RANGE_ADD, 350, 700, 32'sd3));
        queue_req(mk_req(FUNC_RANGE_QUERY, 299, 401, 0));
        queue_req(mk_req(FUNC_RANGE_QUERY, 5, 4, 0));
        queue_req(mk_req(FUNC_RANGE_QUERY, NPOS - 1, 0, 0));
        queue_req(mk_req(FUNC_RANGE_ASSIGN, 9, 8, 32'sd55));
        queue_req(mk_req(FUNC_RANGE_ADD, 700, 3, 32'sd55));
        queue_req(mk_req(FUNC_POINT_SET, 8, 7, 32'sd99));
        queue_req(mk_req(3'd5, 0, NPOS - 1, 32'sd1));
        queue_req(mk_req(3'd6, 10, 20, 32'sd1));
        queue_req(mk_req(3'd7, NPOS - 1, NPOS - 1, -32'sd1));
        queue_req(mk_req(FUNC_RANGE_QUERY, 0, NPOS - 1, 0));
        for (int i = 0; i < N_RANDOM; i++) begin
            tree_req_t rq;
            rq = rand_request();
            if (i == 600) rq.drain = 1'b1;
            queue_req(rq);
        end
        for (int i = 0; i < NPOS; i++) shadow[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Request driver: bursty gaps while plenty of stimulus remains.
    int gap_left = 0;
    always @(posedge aclk) begin
        tree_req_t cur, nxt;
        bit has_res;
        sum_res_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur = mk_req(s_func, s_left_pos, s_right_pos, s_operand);
                apply_request(cur, has_res, res);
                if (has_res) expected_sums = {expected_sums, res};
                accepted++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_valid <= 1'b0;
                    stim_done <= 1'b1;
                end else if (pending_reqs[0].drain && expected_sums.size() != 0) begin
                    s_valid <= 1'b0;   // wait for every outstanding sum
                end else begin
                    nxt = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_func <= nxt.func;
                    s_left_pos <= nxt.lpos;
                    s_right_pos <= nxt.rpos;
                    s_operand <= nxt.opd;
                    if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 15);
                end
            end
        end
    end

    // Receiver: random stall bursts plus one long hold that backs up the engine.
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && accepted >= STALL_AT) begin
            hold_done <= 1'b1;
            hold_left <= STALL_LEN;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);   // start a random stall burst
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        sum_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result sum=%0d bad=%0b", m_range_sum, m_bad_range);
            end else begin
                want = expected_sums.pop_front();
                if (m_range_sum !== want.sum || m_bad_range !== want.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: sum exp=%0d got=%0d, bad_range exp=%0b got=%0b",
                                 want.sum, m_range_sum, want.bad, m_bad_range);
                end
            end
        end
    end

    // End of run: drain, let the last sweep settle, then report.
    int cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_sums.size() == 0);
        repeat (2000) @(posedge aclk);
        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/lrst_pkg.sv
design/lrst_ram.sv
design/lazy_range_sum_tree_top.sv
design/lrst_checker.sv
dv/lazy_range_sum_tree_top_tb.sv
